// ===== rtl/ipv6_address_text_parser_unit_assert.svh =====
// Assertion macros shared by the checker of the IPv6 address text parser.
// Depends on nothing; each macro expects signals named clock and reset in scope.
`ifndef IPV6_ADDRESS_TEXT_PARSER_UNIT_ASSERT_SVH
`define IPV6_ADDRESS_TEXT_PARSER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IATP_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IATP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/iatp_pkg.sv =====
// Shared types, character codes and tables of the IPv6 address text parser.
// Depends on nothing; every other RTL module imports it.
package iatp_pkg;

   localparam int IATP_QUEUE_DEPTH = 4;

   // Character codes the parser recognizes.
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_COLON = 8'h3a;
   localparam logic [7:0] CH_SLASH = 8'h2f;
   localparam logic [7:0] CH_LESS  = 8'h3c;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LF    = 8'h66;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UF    = 8'h46;

   // The unspecified-address literal, one character per position.
   localparam logic [7:0] UNSPEC_TEXT [8] = '{
      8'h3c, 8'h75, 8'h6e, 8'h73, 8'h70, 8'h65, 8'h63, 8'h3e
   };

   // Character classes handed from the front to the back.
   localparam logic [2:0] KIND_NUL   = 3'd0;
   localparam logic [2:0] KIND_HEX   = 3'd1;
   localparam logic [2:0] KIND_COLON = 3'd2;
   localparam logic [2:0] KIND_SLASH = 3'd3;
   localparam logic [2:0] KIND_OTHER = 3'd4;

   typedef struct packed {
      logic [7:0] char_code;
      logic       mode;
   } req_type;

   typedef struct packed {
      logic        ok;
      logic [63:0] addr_high;
      logic [63:0] addr_low;
      logic [7:0]  prefix_len;
   } rsp_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       mode;
      logic [2:0] kind;
      logic [3:0] digit;
      logic       is_dec;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ===== rtl/iatp_front.sv =====
// Front end of the IPv6 address text parser: accepts words and classifies characters.
// Depends on iatp_pkg.
module iatp_front
   import iatp_pkg::*;
(
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   input  queue_status_type status,
   output logic             push,
   output item_type         push_item
);

   logic [7:0] c;

   assign c         = req_data.char_code;
   assign req_stall = status.full;
   assign push      = req_valid && !status.full;

   always_comb begin
      push_item.char_code = c;
      push_item.mode      = req_data.mode;
      push_item.is_dec    = (c inside {[CH_ZERO:CH_NINE]});
      push_item.digit     = 4'd0;
      push_item.kind      = KIND_OTHER;
      if (c == CH_NUL) begin
         push_item.kind = KIND_NUL;
      end else if (c inside {[CH_ZERO:CH_NINE]}) begin
         push_item.kind  = KIND_HEX;
         push_item.digit = 4'(c - CH_ZERO);
      end else if (c inside {[CH_LA:CH_LF]}) begin
         push_item.kind  = KIND_HEX;
         push_item.digit = 4'(c - CH_LA + 8'd10);
      end else if (c inside {[CH_UA:CH_UF]}) begin
         push_item.kind  = KIND_HEX;
         push_item.digit = 4'(c - CH_UA + 8'd10);
      end else if (c == CH_COLON) begin
         push_item.kind = KIND_COLON;
      end else if (c == CH_SLASH) begin
         push_item.kind = KIND_SLASH;
      end
   end

endmodule

// ===== rtl/iatp_queue.sv =====
// Small FIFO of classified characters between the front and back of the parser.
// Depends on iatp_pkg.
module iatp_queue
   import iatp_pkg::*;
#(
   parameter int DEPTH = IATP_QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  item_type         push_item,
   input  logic             pop,
   output item_type         pop_item,
   output queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type           mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_item     = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/iatp_back.sv =====
// Back end of the IPv6 address text parser: the parse state machine and result register.
// Depends on iatp_pkg.
module iatp_back
   import iatp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type status,
   input  item_type         item,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data
);

   localparam logic [2:0] PH_START  = 3'd0;
   localparam logic [2:0] PH_HEAD   = 3'd1;
   localparam logic [2:0] PH_LEAD   = 3'd2;
   localparam logic [2:0] PH_TAIL   = 3'd3;
   localparam logic [2:0] PH_PREFIX = 3'd4;
   localparam logic [2:0] PH_UNSPEC = 3'd5;

   logic [2:0]  phase_ff, phase_in;
   logic        mode_ff, mode_in;
   logic        failed_ff, failed_in;
   logic [3:0]  head_cnt_ff, head_cnt_in;
   logic [3:0]  tail_cnt_ff, tail_cnt_in;
   logic [15:0] accum_ff, accum_in;
   logic        digit_ff, digit_in;
   logic [3:0]  upos_ff, upos_in;
   logic [7:0]  prefix_ff, prefix_in;
   logic [15:0] head_ff [8];
   logic [15:0] head_in [8];
   logic [15:0] tail_ff [8];
   logic [15:0] tail_in [8];
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic        out_free;
   logic        is_nul;
   logic        start_unspec;
   logic [2:0]  eff_phase;
   logic        eff_mode;
   logic        close_head_wr;
   logic        close_tail_wr;
   logic        close_ok;
   logic [4:0]  group_total;
   logic [3:0]  head_cnt_view;
   logic [3:0]  tail_cnt_view;
   logic [15:0] head_view [8];
   logic [15:0] tail_view [8];
   logic [15:0] grp [8];
   logic [4:0]  tail_pos;
   logic        res_ok;
   logic [10:0] pfx_sum;
   rsp_type     result;

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign is_nul       = (item.kind == KIND_NUL);
   assign pop          = !status.empty && (!is_nul || out_free);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;

   // A string's first character begins the address part unless it opens <unspec>.
   assign eff_phase    = (phase_ff == PH_START) ? PH_HEAD : phase_ff;
   assign eff_mode     = (phase_ff == PH_START) ? item.mode : mode_ff;
   assign start_unspec = (phase_ff == PH_START) && (item.char_code == CH_LESS) && !item.mode;

   assign group_total  = {1'b0, head_cnt_ff} + {1'b0, tail_cnt_ff};
   assign close_head_wr = (eff_phase == PH_HEAD);
   assign close_tail_wr = (eff_phase == PH_TAIL) && digit_ff;

   always_comb begin
      close_ok = 1'b0;
      if (eff_phase == PH_HEAD) begin
         close_ok = digit_ff && (head_cnt_ff == 4'd7);
      end else if (eff_phase == PH_TAIL) begin
         close_ok = digit_ff ? (group_total < 5'd7) : (tail_cnt_ff == 4'd0);
      end
   end

   // Group arrays as they stand once the pending group has closed the address.
   always_comb begin
      head_view     = head_ff;
      tail_view     = tail_ff;
      head_cnt_view = head_cnt_ff;
      tail_cnt_view = tail_cnt_ff;
      if (close_head_wr) begin
         head_view[7]  = accum_ff;
         head_cnt_view = 4'd8;
      end
      if (close_tail_wr) begin
         for (int i = 0; i < 7; i++) begin
            tail_view[i] = tail_ff[i+1];
         end
         tail_view[7]  = accum_ff;
         tail_cnt_view = tail_cnt_ff + 1'b1;
      end
   end

   // Head groups fill from the top; tail groups sit right-aligned at the bottom.
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         grp[i]   = 16'd0;
         tail_pos = 5'(i) + {1'b0, tail_cnt_view};
         if (4'(i) < head_cnt_view) begin
            grp[i] = head_view[i];
         end
         if (tail_pos >= 5'd8) begin
            grp[i] = grp[i] | tail_view[i];
         end
      end
   end

   always_comb begin
      res_ok = 1'b0;
      if (!failed_ff) begin
         if (eff_phase == PH_UNSPEC) begin
            res_ok = (upos_ff == 4'd8);
         end else if (eff_phase == PH_PREFIX) begin
            res_ok = digit_ff;
         end else if (!eff_mode) begin
            res_ok = close_ok;
         end
      end
      result.ok         = res_ok;
      result.addr_high  = 64'd0;
      result.addr_low   = 64'd0;
      result.prefix_len = (res_ok && eff_mode) ? prefix_ff : 8'd0;
      if (res_ok && (eff_phase != PH_UNSPEC)) begin
         result.addr_high = {grp[0], grp[1], grp[2], grp[3]};
         result.addr_low  = {grp[4], grp[5], grp[6], grp[7]};
      end
   end

   assign pfx_sum = ({3'b0, prefix_ff} << 3) + ({3'b0, prefix_ff} << 1) + {7'b0, item.digit};

   always_comb begin
      phase_in     = phase_ff;
      mode_in      = mode_ff;
      failed_in    = failed_ff;
      head_cnt_in  = head_cnt_ff;
      tail_cnt_in  = tail_cnt_ff;
      accum_in     = accum_ff;
      digit_in     = digit_ff;
      upos_in      = upos_ff;
      prefix_in    = prefix_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (pop) begin
         if (start_unspec) begin
            mode_in  = 1'b0;
            phase_in = PH_UNSPEC;
            upos_in  = 4'd1;
         end else if (is_nul) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = result;
            mode_in      = eff_mode;
            phase_in     = PH_START;
            failed_in    = 1'b0;
            head_cnt_in  = 4'd0;
            tail_cnt_in  = 4'd0;
            accum_in     = 16'd0;
            digit_in     = 1'b0;
            upos_in      = 4'd0;
            prefix_in    = 8'd0;
         end else begin
            mode_in  = eff_mode;
            phase_in = eff_phase;
            if (!failed_ff) begin
               case (eff_phase)
                  PH_HEAD, PH_TAIL: begin
                     if (item.kind == KIND_HEX) begin
                        accum_in = {accum_ff[11:0], item.digit};
                        digit_in = 1'b1;
                        if (accum_ff[15:12] != 4'd0) begin
                           failed_in = 1'b1;
                        end
                     end else if (item.kind == KIND_COLON) begin
                        if (digit_ff) begin
                           if (eff_phase == PH_HEAD) begin
                              if (head_cnt_ff >= 4'd7) begin
                                 failed_in = 1'b1;
                              end else begin
                                 head_in[head_cnt_ff[2:0]] = accum_ff;
                                 head_cnt_in = head_cnt_ff + 1'b1;
                                 accum_in    = 16'd0;
                                 digit_in    = 1'b0;
                              end
                           end else begin
                              if (group_total >= 5'd7) begin
                                 failed_in = 1'b1;
                              end else begin
                                 tail_in     = tail_view;
                                 tail_cnt_in = tail_cnt_ff + 1'b1;
                                 accum_in    = 16'd0;
                                 digit_in    = 1'b0;
                              end
                           end
                        end else if (eff_phase == PH_HEAD) begin
                           phase_in = (head_cnt_ff == 4'd0) ? PH_LEAD : PH_TAIL;
                        end else begin
                           failed_in = 1'b1;
                        end
                     end else if ((item.kind == KIND_SLASH) && eff_mode) begin
                        if (close_ok) begin
                           head_in     = head_view;
                           tail_in     = tail_view;
                           head_cnt_in = head_cnt_view;
                           tail_cnt_in = tail_cnt_view;
                           phase_in    = PH_PREFIX;
                           digit_in    = 1'b0;
                           prefix_in   = 8'd0;
                        end else begin
                           failed_in = 1'b1;
                        end
                     end else begin
                        failed_in = 1'b1;
                     end
                  end
                  PH_LEAD: begin
                     if (item.kind == KIND_COLON) begin
                        phase_in = PH_TAIL;
                     end else begin
                        failed_in = 1'b1;
                     end
                  end
                  PH_PREFIX: begin
                     if (item.is_dec) begin
                        digit_in = 1'b1;
                        if (pfx_sum > 11'd128) begin
                           failed_in = 1'b1;
                        end else begin
                           prefix_in = pfx_sum[7:0];
                        end
                     end else begin
                        failed_in = 1'b1;
                     end
                  end
                  PH_UNSPEC: begin
                     if ((upos_ff < 4'd8) && (item.char_code == UNSPEC_TEXT[upos_ff[2:0]])) begin
                        upos_in = upos_ff + 1'b1;
                     end else begin
                        failed_in = 1'b1;
                     end
                  end
                  default: begin
                     failed_in = 1'b1;
                  end
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         mode_ff      <= 1'b0;
         failed_ff    <= 1'b0;
         head_cnt_ff  <= 4'd0;
         tail_cnt_ff  <= 4'd0;
         accum_ff     <= 16'd0;
         digit_ff     <= 1'b0;
         upos_ff      <= 4'd0;
         prefix_ff    <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         mode_ff      <= mode_in;
         failed_ff    <= failed_in;
         head_cnt_ff  <= head_cnt_in;
         tail_cnt_ff  <= tail_cnt_in;
         accum_ff     <= accum_in;
         digit_ff     <= digit_in;
         upos_ff      <= upos_in;
         prefix_ff    <= prefix_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff     <= head_in;
      tail_ff     <= tail_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== rtl/ipv6_address_text_parser_unit.sv =====
// Top level of the IPv6 address text parser: front classifier, queue and parse back end.
// Depends on iatp_pkg, iatp_front, iatp_queue and iatp_back.
//
// The parser takes an IPv6 address as text, one ASCII character per request word, and
// a NUL character ends each string. The mode bit of the first word of a string chooses
// between a plain address (mode 0) and an address followed by a slash and a decimal
// prefix length (mode 1). Each NUL produces exactly one response word carrying ok, the
// 128-bit address split into a high and a low half, and the prefix length; when ok is
// low all other fields are zero. In mode 0 the exact string "<unspec>" yields the
// all-zero address. The block sustains one character per clock cycle: the front end
// classifies a word in the cycle it is accepted and writes it to a queue of
// QUEUE_DEPTH entries, the back end consumes one queued character per cycle, and with
// an empty queue a NUL passes from its queue entry straight to the output register,
// which then offers its response to the receiver. Only a NUL waits on the back end,
// and only while an earlier response is still held in the output register; during
// such a stall the queue holds up to QUEUE_DEPTH words, the waiting NUL among them,
// before req_stall rises.
module ipv6_address_text_parser_unit
   import iatp_pkg::*;
#(
   parameter int QUEUE_DEPTH = IATP_QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // Classified characters travel from the front end to the queue.
   queue_status_type q_status;
   logic             q_push;
   item_type         q_push_item;
   logic             q_pop;
   item_type         q_pop_item;

   // The front end only looks at the character; it never holds parse state.
   iatp_front u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .status    (q_status),
      .push      (q_push),
      .push_item (q_push_item)
   );

   iatp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .pop       (q_pop),
      .pop_item  (q_pop_item),
      .status    (q_status)
   );

   // The back end owns the group registers, the failure flag and the response register.
   iatp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .status    (q_status),
      .item      (q_pop_item),
      .pop       (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/iatp_checker.sv =====
// Port-level checker for the IPv6 address text parser, bound to the top level.
// Depends on iatp_pkg and ipv6_address_text_parser_unit_assert.svh.
`include "ipv6_address_text_parser_unit_assert.svh"

module iatp_checker
   import iatp_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   logic req_held;
   logic rsp_held;
   logic rsp_failed;
   logic rsp_zero;

   assign req_held   = req_valid && req_stall;
   assign rsp_held   = rsp_valid && rsp_stall;
   assign rsp_failed = rsp_valid && !rsp_data.ok;
   assign rsp_zero   = (rsp_data.addr_high == 64'd0) && (rsp_data.addr_low == 64'd0)
                       && (rsp_data.prefix_len == 8'd0);

   // A request word that is stalled stays offered and unchanged.
   `IATP_ASSERT_NEXT(a_req_hold, req_held, req_valid && $stable(req_data), "request changed")

   // A response word that is stalled stays offered and unchanged.
   `IATP_ASSERT_NEXT(a_rsp_hold, rsp_held, rsp_valid && $stable(rsp_data), "response changed")

   // A failed parse reports no address and no prefix.
   `IATP_ASSERT_SAME(a_fail_zero, rsp_failed, rsp_zero, "failed parse carries data")

   // A prefix length never exceeds the width of an address.
   `IATP_ASSERT_SAME(a_prefix_range, rsp_valid, rsp_data.prefix_len <= 8'd128, "prefix over 128")

endmodule

bind ipv6_address_text_parser_unit iatp_checker u_checker (.*);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking regression bench for the IPv6 address text parser unit.
// Depends on iatp_pkg for the word types and character codes, and on the RTL top level.
module tb_top;
   import iatp_pkg::*;

   // Number of characters the whole run sends before the random phase stops.
   localparam int unsigned RANDOM_CHARS = 1900;
   // Cycles without any handshake after which the run is declared hung.
   localparam int unsigned QUIET_LIMIT = 2000;
   // Cycles to keep watching after the last expected response, to catch extra words.
   localparam int unsigned SETTLE_CYCLES = 10;
   localparam int unsigned PREFIX_MAX = 128;
   localparam int unsigned GROUP_MAX = 32'h0000_ffff;
   localparam int unsigned GROUP_SLOTS = 8;

   // Where the parse of the current string stands.
   typedef enum logic [2:0] {
      PS_START,
      PS_HEAD,
      PS_LEAD,
      PS_TAIL,
      PS_PREFIX,
      PS_UNSPEC
   } parse_state_type;

   logic    clock;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   ipv6_address_text_parser_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Parser state as the bench believes it to be. It is advanced when a word is handed
   // to the driver, which is safe because words are accepted strictly in order.
   parse_state_type parse_state = PS_START;
   logic         cur_mode = 1'b0;
   bit           parse_bad = 1'b0;
   logic [15:0]  head_grp [GROUP_SLOTS];
   logic [15:0]  tail_grp [GROUP_SLOTS];
   int           n_head = 0;
   int           n_tail = 0;
   int unsigned  group_val = 0;
   bit           digit_seen = 1'b0;
   int           unspec_idx = 0;
   int unsigned  prefix_val = 0;

   // Responses predicted but not yet seen on the response channel, oldest first.
   rsp_type expected_addresses [$];

   int unsigned failures = 0;
   int unsigned chars_sent = 0;
   int unsigned strings_sent = 0;
   int unsigned responses_seen = 0;
   int unsigned ok_seen = 0;
   int unsigned tx_burst_left = 0;
   int unsigned quiet_cycles = 0;

   // Receiver stall generator state.
   int unsigned rx_cycle = 0;
   int unsigned rx_style = 0;
   int unsigned rx_hold = 0;

   function automatic int hex_nibble(input logic [7:0] ch);
      if (ch >= CH_ZERO && ch <= CH_NINE) return int'(ch - CH_ZERO);
      if (ch >= CH_LA && ch <= CH_LF) return int'(ch - CH_LA) + 10;
      if (ch >= CH_UA && ch <= CH_UF) return int'(ch - CH_UA) + 10;
      return -1;
   endfunction

   function automatic void clear_parse();
      parse_state = PS_START;
      parse_bad = 1'b0;
      n_head = 0;
      n_tail = 0;
      group_val = 0;
      digit_seen = 1'b0;
      unspec_idx = 0;
      prefix_val = 0;
   endfunction

   // Ends the address part at a slash or at the NUL. A pending group is stored, and the
   // group count is checked against whether a double colon was seen.
   function automatic bit finish_address();
      if (parse_state == PS_HEAD) begin
         if (!digit_seen || n_head != GROUP_SLOTS - 1) return 1'b0;
         head_grp[GROUP_SLOTS - 1] = group_val[15:0];
         n_head = GROUP_SLOTS;
         return 1'b1;
      end
      if (parse_state == PS_TAIL) begin
         if (digit_seen) begin
            if (n_head + n_tail >= GROUP_SLOTS - 1) return 1'b0;
            tail_grp[n_tail] = group_val[15:0];
            n_tail++;
            return 1'b1;
         end
         // A trailing single colon after a tail group leaves no digit behind it.
         return n_tail == 0;
      end
      return 1'b0;
   endfunction

   // Advances the parse by one character and queues the response a NUL produces.
   task automatic parse_text_char(input logic [7:0] ch, input logic m);
      int          nib;
      int unsigned pv;
      bit          ok_now;
      bit          zero_out;
      logic [15:0] grp [GROUP_SLOTS];
      rsp_type     res;
      if (parse_state == PS_START) begin
         cur_mode = m;
         parse_state = PS_HEAD;
         if (ch == CH_LESS && !m) begin
            parse_state = PS_UNSPEC;
            unspec_idx = 1;
            return;
         end
      end
      if (ch == CH_NUL) begin
         ok_now = !parse_bad;
         zero_out = 1'b0;
         if (ok_now) begin
            if (parse_state == PS_UNSPEC) begin
               ok_now = (unspec_idx == GROUP_SLOTS);
               zero_out = 1'b1;
            end else if (parse_state == PS_PREFIX) begin
               ok_now = digit_seen;
            end else if (cur_mode) begin
               ok_now = 1'b0;
            end else begin
               ok_now = finish_address();
            end
         end
         res = '0;
         if (ok_now && !zero_out) begin
            for (int i = 0; i < GROUP_SLOTS; i++) grp[i] = '0;
            for (int i = 0; i < n_head; i++) grp[i] = head_grp[i];
            // Tail groups sit at the bottom; the gap left by the double colon is zero.
            for (int i = 0; i < n_tail; i++) grp[GROUP_SLOTS - n_tail + i] = tail_grp[i];
            res.addr_high = {grp[0], grp[1], grp[2], grp[3]};
            res.addr_low = {grp[4], grp[5], grp[6], grp[7]};
         end
         res.ok = ok_now;
         res.prefix_len = (ok_now && cur_mode) ? prefix_val[7:0] : 8'd0;
         expected_addresses.push_back(res);
         clear_parse();
         return;
      end
      if (parse_bad) return;
      case (parse_state)
         PS_HEAD, PS_TAIL: begin
            nib = hex_nibble(ch);
            if (nib >= 0) begin
               group_val = (group_val << 4) | unsigned'(nib);
               digit_seen = 1'b1;
               if (group_val > GROUP_MAX) parse_bad = 1'b1;
            end else if (ch == CH_COLON) begin
               if (digit_seen) begin
                  if (parse_state == PS_HEAD) begin
                     if (n_head >= GROUP_SLOTS - 1) begin
                        parse_bad = 1'b1;
                     end else begin
                        head_grp[n_head] = group_val[15:0];
                        n_head++;
                     end
                  end else begin
                     if (n_head + n_tail >= GROUP_SLOTS - 1) begin
                        parse_bad = 1'b1;
                     end else begin
                        tail_grp[n_tail] = group_val[15:0];
                        n_tail++;
                     end
                  end
                  group_val = 0;
                  digit_seen = 1'b0;
               end else if (parse_state == PS_HEAD) begin
                  // A colon with no digit in front opens the double colon.
                  parse_state = (n_head == 0) ? PS_LEAD : PS_TAIL;
               end else begin
                  parse_bad = 1'b1;
               end
            end else if (ch == CH_SLASH && cur_mode) begin
               if (finish_address()) begin
                  parse_state = PS_PREFIX;
                  digit_seen = 1'b0;
                  prefix_val = 0;
               end else begin
                  parse_bad = 1'b1;
               end
            end else begin
               parse_bad = 1'b1;
            end
         end
         PS_LEAD: begin
            // A leading colon must be followed straight away by a second one.
            if (ch == CH_COLON) parse_state = PS_TAIL;
            else parse_bad = 1'b1;
         end
         PS_PREFIX: begin
            if (ch >= CH_ZERO && ch <= CH_NINE) begin
               pv = prefix_val * 10 + int'(ch - CH_ZERO);
               digit_seen = 1'b1;
               if (pv > PREFIX_MAX) parse_bad = 1'b1;
               else prefix_val = pv;
            end else begin
               parse_bad = 1'b1;
            end
         end
         PS_UNSPEC: begin
            if (unspec_idx < GROUP_SLOTS && ch == UNSPEC_TEXT[unspec_idx]) unspec_idx++;
            else parse_bad = 1'b1;
         end
         default: parse_bad = 1'b1;
      endcase
   endtask

   // Sends one request word. The sender runs in bursts of random length; a new burst
   // may start after a few idle cycles, and long bursts give stretches with no idling.
   task automatic send_word(input logic [7:0] ch, input logic m);
      int unsigned gap;
      if (tx_burst_left == 0) begin
         tx_burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
         gap = $urandom_range(0, 5);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      tx_burst_left--;
      parse_text_char(ch, m);
      req_valid <= 1'b1;
      req_data <= '{char_code: ch, mode: m};
      do @(posedge clock); while (req_stall !== 1'b0);
      chars_sent++;
   endtask

   // Sends a string and its terminating NUL. Only the first word's mode bit matters, so
   // the rest carry random mode bits. A nonzero flip_pct swaps characters for random bytes.
   task automatic send_text(input string s, input logic m, input int unsigned flip_pct = 0);
      logic [7:0] ch;
      for (int i = 0; i < s.len(); i++) begin
         ch = s[i];
         if (flip_pct != 0 && $urandom_range(0, 99) < flip_pct) ch = 8'($urandom_range(1, 255));
         send_word(ch, (i == 0) ? m : logic'($urandom_range(0, 1)));
      end
      send_word(CH_NUL, (s.len() == 0) ? m : logic'($urandom_range(0, 1)));
      strings_sent++;
   endtask

   // Holds the request channel idle until every predicted response has been checked.
   task automatic wait_for_responses();
      req_valid <= 1'b0;
      tx_burst_left = 0;
      do @(posedge clock); while (expected_addresses.size() != 0);
   endtask

   function automatic string hex_group_text();
      logic [15:0] v;
      string       s;
      case ($urandom_range(0, 9))
         0: v = 16'h0000;
         1: v = 16'hffff;
         2: v = 16'($urandom_range(0, 15));
         default: v = 16'($urandom);
      endcase
      if ($urandom_range(0, 5) == 0) s = $sformatf("%04h", v);
      else s = $sformatf("%0h", v);
      // A fifth digit is legal behind a leading zero and overflows otherwise.
      if ($urandom_range(0, 11) == 0) s = {"0", s};
      if ($urandom_range(0, 39) == 0) s = {$sformatf("%0h", $urandom_range(1, 15)),
                                           $sformatf("%04h", v)};
      if ($urandom_range(0, 1) == 1) s = s.toupper();
      return s;
   endfunction

   function automatic string prefix_text();
      int unsigned v;
      string       s;
      case ($urandom_range(0, 9))
         0: v = 0;
         1: v = PREFIX_MAX;
         2: v = $urandom_range(PREFIX_MAX + 1, 999);
         default: v = $urandom_range(0, PREFIX_MAX);
      endcase
      s = $sformatf("%0d", v);
      if ($urandom_range(0, 5) == 0) s = {"0", s};
      if ($urandom_range(0, 24) == 0) s = "";
      return s;
   endfunction

   // Mostly legal addresses: full eight-group form or compressed around a double colon,
   // now and then with one group too many or too few. Mode 1 mostly gets a prefix, and
   // mode 0 occasionally gets one it must reject.
   function automatic string address_text(input logic m);
      string s;
      int    total;
      int    lead;
      s = "";
      if ($urandom_range(0, 2) == 0) begin
         total = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 9) : 8;
         for (int k = 0; k < total; k++) begin
            if (k != 0) s = {s, ":"};
            s = {s, hex_group_text()};
         end
      end else begin
         total = ($urandom_range(0, 11) == 0) ? 8 : $urandom_range(0, 7);
         lead = $urandom_range(0, total);
         for (int k = 0; k < lead; k++) begin
            if (k != 0) s = {s, ":"};
            s = {s, hex_group_text()};
         end
         s = {s, "::"};
         for (int k = 0; k < total - lead; k++) begin
            if (k != 0) s = {s, ":"};
            s = {s, hex_group_text()};
         end
      end
      if (m ? ($urandom_range(0, 14) != 0) : ($urandom_range(0, 14) == 0))
         s = {s, "/", prefix_text()};
      return s;
   endfunction

   // Structural damage to an otherwise sensible string.
   function automatic string mangle_text(input string s);
      int pos;
      if (s.len() == 0) return ":";
      pos = $urandom_range(0, s.len() - 1);
      case ($urandom_range(0, 5))
         0: return {s.substr(0, pos - 1), ":", s.substr(pos, s.len() - 1)};
         1: return {s.substr(0, pos - 1), s.substr(pos + 1, s.len() - 1)};
         2: return s.substr(0, pos);
         3: return {s, ":"};
         4: return {s.substr(0, pos - 1), "::", s.substr(pos, s.len() - 1)};
         default: return {s.substr(0, pos - 1), " ", s.substr(pos, s.len() - 1)};
      endcase
   endfunction

   function automatic string unspec_variant();
      case ($urandom_range(0, 7))
         0: return "<unspec";
         1: return "<unspe>";
         2: return "<unspec>>";
         3: return "<UNSPEC>";
         4: return "<unspec>/0";
         5: return "<";
         default: return "<unspec>";
      endcase
   endfunction

   // Short runs of characters drawn partly from the parser's own alphabet and partly
   // from the whole byte range, so every bit of the character field toggles.
   task automatic send_noise();
      string      alphabet;
      int         n;
      logic [7:0] ch;
      alphabet = "0123456789abcdefABCDEF:/<>x -+";
      n = $urandom_range(0, 10);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 1) == 0) ch = alphabet[$urandom_range(0, alphabet.len() - 1)];
         else ch = 8'($urandom_range(1, 255));
         send_word(ch, 1'($urandom_range(0, 1)));
      end
      send_word(CH_NUL, 1'($urandom_range(0, 1)));
      strings_sent++;
   endtask

   // Legal plain addresses: full form, extremes of group values, and the double colon at
   // the start, in the middle and at the end.
   task automatic test_plain_addresses();
      send_text("1:2:3:4:5:6:7:8", 1'b0);
      send_text("FFFF:ffff:FfFf:0:00:000:0000:00000", 1'b0);
      send_text("::", 1'b0);
      send_text("::1", 1'b0);
      send_text("1::", 1'b0);
      send_text("2001:DB8::8:800:200C:417A", 1'b0);
      send_text("1:2:3:4::5:6:7", 1'b0);
      send_text("::1:2:3:4:5:6:7", 1'b0);
   endtask

   // Text that must be rejected: group count wrong, group too large, bad colons,
   // stray characters, a slash without prefix mode, and the empty string.
   task automatic test_malformed_addresses();
      send_text("", 1'b0);
      send_text("1:2:3:4:5:6:7", 1'b0);
      send_text("1:2:3:4:5:6:7:8:9", 1'b0);
      send_text("1::2:3:4:5:6:7:8", 1'b0);
      send_text("12345::", 1'b0);
      send_text("1::2::3", 1'b0);
      send_text("1:::2", 1'b0);
      send_text(":1::", 1'b0);
      send_text("1::2:", 1'b0);
      send_text(" ::1", 1'b0);
      send_text("0x1::", 1'b0);
      send_text("-1::", 1'b0);
      send_text("::1/64", 1'b0);
      send_word(8'hff, 1'b0);
      send_word(CH_NUL, 1'b1);
      strings_sent++;
   endtask

   // The unspecified literal is accepted only exactly and only without prefix mode.
   task automatic test_unspec_literal();
      send_text("<unspec>", 1'b0);
      send_text("<unspec", 1'b0);
      send_text("<unspec>x", 1'b0);
      send_text("<UNSPEC>", 1'b0);
      send_text("<unspec>", 1'b1);
      send_text("<", 1'b0);
   endtask

   // Prefix mode: both range limits, leading zeros, overflow, missing digits or slash.
   task automatic test_prefix_lengths();
      send_text("::/0", 1'b1);
      send_text("1:2:3:4:5:6:7:8/128", 1'b1);
      send_text("::1/064", 1'b1);
      send_text("::/0128", 1'b1);
      send_text("::/129", 1'b1);
      send_text("::/1000", 1'b1);
      send_text("::/", 1'b1);
      send_text("::", 1'b1);
      send_text("::/12a", 1'b1);
      send_text("1::/ 1", 1'b1);
      send_text("", 1'b1);
   endtask

   // Three pairs of strings; after each pair the sender waits for all responses.
   task automatic test_drain_between_strings();
      for (int i = 0; i < 3; i++) begin
         send_text(address_text(1'b0), 1'b0);
         send_text(address_text(1'b1), 1'b1);
         wait_for_responses();
      end
   endtask

   // Mostly well-formed strings with random content, mixed with damaged strings, literal
   // variants and noise. Now and then the sender drains the block completely.
   task automatic test_random_strings();
      int unsigned pick;
      logic        m;
      while (chars_sent < RANDOM_CHARS) begin
         pick = $urandom_range(0, 99);
         m = 1'($urandom_range(0, 1));
         if (pick < 55) send_text(address_text(m), m);
         else if (pick < 72) send_text(address_text(m), m, $urandom_range(3, 15));
         else if (pick < 82) send_text(mangle_text(address_text(m)), m);
         else if (pick < 90) send_text(unspec_variant(), $urandom_range(0, 3) == 0);
         else send_noise();
         if ($urandom_range(0, 39) == 0) wait_for_responses();
      end
   endtask

   // Receiver stalls: the style is drawn anew at regular intervals among never stalling,
   // stalling at random, and holding stall high or low for runs of random length.
   always @(posedge clock) begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle % 128 == 0) rx_style <= $urandom_range(0, 2);
      case (rx_style)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 2) == 0);
         default: begin
            if (rx_hold != 0) begin
               rx_hold <= rx_hold - 1;
            end else begin
               rsp_stall <= !rsp_stall;
               rx_hold <= $urandom_range(0, 12);
            end
         end
      endcase
   end

   task automatic report_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
      if (got !== want) begin
         failures++;
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      end
   endtask

   // Every accepted response word is compared with the oldest prediction. Signals are
   // read in the active region of the edge, so they hold their values from before it.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         responses_seen++;
         if (expected_addresses.size() == 0) begin
            failures++;
            $display("%0t: unexpected response, expected none actual %h", $time, rsp_data);
         end else begin
            want = expected_addresses.pop_front();
            if (want.ok) ok_seen++;
            report_field("ok", 64'(want.ok), 64'(rsp_data.ok));
            report_field("addr_high", want.addr_high, rsp_data.addr_high);
            report_field("addr_low", want.addr_low, rsp_data.addr_low);
            report_field("prefix_len", 64'(want.prefix_len), 64'(rsp_data.prefix_len));
         end
      end
   end

   // Hang detection: a long run of cycles with no word moving on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Timeout after %0d cycles with no word moving.", quiet_cycles);
         $display("ipv6_address_text_parser_unit regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      clear_parse();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_plain_addresses();
      test_malformed_addresses();
      test_unspec_literal();
      test_prefix_lengths();
      test_drain_between_strings();
      test_random_strings();
      // Let the last responses arrive, then watch a little longer for stray words.
      wait_for_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d strings in %0d characters; checked %0d responses, %0d of them ok.",
               strings_sent, chars_sent, responses_seen, ok_seen);
      $display("Covered plain, compressed and prefixed addresses, the unspecified literal,");
      $display("malformed text and random bytes, with %0d failures.", failures);
      if (failures == 0) begin
         $display("ipv6_address_text_parser_unit regression: pass");
      end else begin
         $display("ipv6_address_text_parser_unit regression: fail");
      end
      $finish;
   end

endmodule

// ===== ipv6_address_text_parser_unit.f =====
+incdir+rtl
rtl/iatp_pkg.sv
rtl/iatp_front.sv
rtl/iatp_queue.sv
rtl/iatp_back.sv
rtl/ipv6_address_text_parser_unit.sv
rtl/iatp_checker.sv
tb/sv/tb_top.sv
